/* sv/bmhq_pkg.sv */
// Shared constants, codes and types of the binary min-heap queue.
package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = IDX_W + 2;

    // Request kinds carried in the input tuser.
    typedef enum logic [0:0] {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // One incoming request.
    typedef struct packed {
        t_kind            kind;
        logic [KEY_W-1:0] key;
    } t_req;

    // One result of a request.
    typedef struct packed {
        logic [KEY_W-1:0] min_key;
        logic             is_empty;
        logic [CNT_W-1:0] entry_count;
        t_status          status;
    } t_rsp;

endpackage

/* sv/binary_min_heap_queue_unit.sv */
// Binary min-heap priority queue: each push or pop request returns the current
// minimum, an empty flag, the entry count and a status. Requests are served one
// at a time. A push reads the parent of the new slot and moves larger parents
// down level by level as the key rises; a pop moves the last entry to the root
// and sinks it level by level. The sift walks the tree through a key memory with
// one write port and two registered read ports. A push into an empty heap, a pop
// of the last entry and rejected requests (pop on empty, push when full) skip the
// sift. A result waits in an output register, so the next request is taken while
// the previous result has not yet been collected.
module binary_min_heap_queue_unit
    import bmhq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] key_in
    input  logic [0:0]  s_axis_tuser,  // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [31:0] min_key, [32] is_empty,
                                       // [39:33] entry_count, [41:40] status, zeros above
);

    t_req             w_req;
    t_rsp             w_rsp;
    logic             w_rsp_valid;
    logic             w_rsp_ready;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_waddr;
    logic [KEY_W-1:0] w_mem_wdata;
    logic [IDX_W-1:0] w_mem_raddr_a;
    logic [IDX_W-1:0] w_mem_raddr_b;
    logic [KEY_W-1:0] w_mem_rdata_a;
    logic [KEY_W-1:0] w_mem_rdata_b;
    logic             r_out_valid;
    t_rsp             r_out;

    assign w_req.kind = t_kind'(s_axis_tuser[0]);
    assign w_req.key  = s_axis_tdata;

    bmhq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_mem_we),
        .i_waddr   (w_mem_waddr),
        .i_wdata   (w_mem_wdata),
        .i_raddr_a (w_mem_raddr_a),
        .i_raddr_b (w_mem_raddr_b),
        .o_rdata_a (w_mem_rdata_a),
        .o_rdata_b (w_mem_rdata_b)
    );

    bmhq_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_req         (w_req),
        .o_rsp_valid   (w_rsp_valid),
        .i_rsp_ready   (w_rsp_ready),
        .o_rsp         (w_rsp),
        .o_mem_we      (w_mem_we),
        .o_mem_waddr   (w_mem_waddr),
        .o_mem_wdata   (w_mem_wdata),
        .o_mem_raddr_a (w_mem_raddr_a),
        .o_mem_raddr_b (w_mem_raddr_b),
        .i_mem_rdata_a (w_mem_rdata_a),
        .i_mem_rdata_b (w_mem_rdata_b)
    );

    // Output register between the engine and the result channel.
    assign w_rsp_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp_ready) begin
            r_out_valid <= w_rsp_valid;
        end
        if (w_rsp_ready && w_rsp_valid) begin
            r_out <= w_rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.status, r_out.entry_count, r_out.is_empty,
                            r_out.min_key};

    // A request always takes the engine out of its idle state.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("engine still ready right after a request");

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.is_empty == (r_out.entry_count == '0))
        else $error("empty flag disagrees with count");

    // A dropped push only happens on a full heap.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_PUSH_FULL)
            |-> r_out.entry_count == CNT_W'(CAPACITY))
        else $error("push reported full on a heap that is not full");

endmodule

/* sv/bmhq_ram.sv */
// Heap key store: one write port, two read ports, registered read data.
module bmhq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports with registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* sv/bmhq_engine.sv */
// Sift engine: walks the heap store level by level for push and pop requests.
module bmhq_engine
    import bmhq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    output logic             o_mem_we,
    output logic [IDX_W-1:0] o_mem_waddr,
    output logic [KEY_W-1:0] o_mem_wdata,
    output logic [IDX_W-1:0] o_mem_raddr_a,
    output logic [IDX_W-1:0] o_mem_raddr_b,
    input  logic [KEY_W-1:0] i_mem_rdata_a,
    input  logic [KEY_W-1:0] i_mem_rdata_b
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_POP_LAST,
        S_DOWN,
        S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [KEY_W-1:0] r_cur, n_cur;
    logic [KEY_W-1:0] r_root;
    t_status          r_status, n_status;

    logic [IDX_W-1:0] w_parent;
    logic [IDX_W-1:0] w_cnt_parent;
    logic [IDX_W:0]   w_left;
    logic [IDX_W:0]   w_right;
    logic             w_left_in;
    logic             w_right_in;
    logic             w_take_left;
    logic             w_take_right;
    logic [KEY_W-1:0] w_best_key;
    logic [IDX_W-1:0] w_best_idx;
    logic [IDX_W-1:0] w_best_left;
    logic [IDX_W-1:0] w_best_right;

    // Tree neighbors of the current hole and of the push slot.
    assign w_parent     = (r_pos - IDX_W'(1)) >> 1;
    assign w_cnt_parent = (r_count[IDX_W-1:0] - IDX_W'(1)) >> 1;
    assign w_left       = {r_pos, 1'b1};
    assign w_right      = {r_pos, 1'b0} + (IDX_W + 1)'(2);
    assign w_left_in    = CMP_W'(w_left) < CMP_W'(r_count);
    assign w_right_in   = CMP_W'(w_right) < CMP_W'(r_count);

    // Smallest of hole key and children; the left child wins a tie.
    always_comb begin
        w_take_left  = w_left_in && (i_mem_rdata_a < r_cur);
        w_best_key   = w_take_left ? i_mem_rdata_a : r_cur;
        w_take_right = w_right_in && (i_mem_rdata_b < w_best_key);
        if (w_take_right) begin
            w_best_idx = w_right[IDX_W-1:0];
            w_best_key = i_mem_rdata_b;
        end else if (w_take_left) begin
            w_best_idx = w_left[IDX_W-1:0];
        end else begin
            w_best_idx = r_pos;
        end
    end

    assign w_best_left  = {w_best_idx[IDX_W-2:0], 1'b1};
    assign w_best_right = {w_best_idx[IDX_W-2:0], 1'b0} + IDX_W'(2);

    // Next state, memory requests and working registers.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pos         = r_pos;
        n_cur         = r_cur;
        n_status      = r_status;
        o_mem_we      = 1'b0;
        o_mem_waddr   = r_pos;
        o_mem_wdata   = r_cur;
        o_mem_raddr_a = w_parent;
        o_mem_raddr_b = w_parent;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_status = ST_OK;
                    if (i_req.kind == REQ_PUSH) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_PUSH_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_cur   = i_req.key;
                            n_pos   = r_count[IDX_W-1:0];
                            n_count = r_count + CNT_W'(1);
                            if (r_count == '0) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = '0;
                                o_mem_wdata = i_req.key;
                                n_state     = S_FIN;
                            end else begin
                                o_mem_raddr_a = w_cnt_parent;
                                n_state       = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_POP_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_count       = r_count - CNT_W'(1);
                            o_mem_raddr_a = r_count[IDX_W-1:0] - IDX_W'(1);
                            n_state       = (r_count == CNT_W'(1)) ? S_FIN : S_POP_LAST;
                        end
                    end
                end
            end
            S_UP: begin
                // Parent key is on port A; move it down while the new key is smaller.
                if (r_cur < i_mem_rdata_a) begin
                    o_mem_we      = 1'b1;
                    o_mem_wdata   = i_mem_rdata_a;
                    n_pos         = w_parent;
                    o_mem_raddr_a = (w_parent - IDX_W'(1)) >> 1;
                    n_state       = (w_parent == '0) ? S_PUT : S_UP;
                end else begin
                    o_mem_we = 1'b1;
                    n_state  = S_FIN;
                end
            end
            S_PUT: begin
                o_mem_we = 1'b1;
                n_state  = S_FIN;
            end
            S_POP_LAST: begin
                // The last entry becomes the key that sinks from the root.
                n_cur         = i_mem_rdata_a;
                n_pos         = '0;
                o_mem_raddr_a = IDX_W'(1);
                o_mem_raddr_b = IDX_W'(2);
                n_state       = S_DOWN;
            end
            S_DOWN: begin
                o_mem_we = 1'b1;
                if (w_best_idx == r_pos) begin
                    n_state = S_FIN;
                end else begin
                    o_mem_wdata   = w_best_key;
                    n_pos         = w_best_idx;
                    o_mem_raddr_a = w_best_left;
                    o_mem_raddr_b = w_best_right;
                end
            end
            S_FIN: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and the root shadow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
        end
        r_pos <= n_pos;
        r_cur <= n_cur;
        if (o_mem_we && (o_mem_waddr == '0)) begin
            r_root <= o_mem_wdata;
        end
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_rsp_valid       = (r_state == S_FIN);
    assign o_rsp.min_key     = (r_count != '0) ? r_root : '0;
    assign o_rsp.is_empty    = (r_count == '0);
    assign o_rsp.entry_count = r_count;
    assign o_rsp.status      = r_status;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the binary min-heap queue, checked against a heap predictor.
module tb;
    import bmhq_pkg::*;

    localparam int GAP_MAX      = 16;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 24;

    // One row of the directed stimulus table.
    typedef struct {
        t_kind            kind;
        logic [KEY_W-1:0] key;
        bit               typed;
        t_rsp             rsp;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] key_in
    logic [0:0]  s_axis_tuser  = '0;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;         // [31:0] min_key, [32] is_empty,
                                       // [39:33] entry_count, [41:40] status
    logic        rx_ready      = 1'b0;
    logic        rx_hold       = 1'b0;

    // Predicted heap contents and the results still owed by the block.
    logic [KEY_W-1:0] heap_keys [CAPACITY];
    int               heap_fill = 0;
    t_rsp             pending_results [$];
    t_row             directed_rows [$];

    int accepted_reqs = 0;
    int checked_rsps  = 0;
    int mismatches    = 0;
    int n_push_ok     = 0;
    int n_push_full   = 0;
    int n_pop_ok      = 0;
    int n_pop_empty   = 0;
    bit tx_no_idle    = 1'b0;

    // The long hold-off overrides the receiver's own ready.
    assign m_axis_tready = rx_ready & ~rx_hold;

    binary_min_heap_queue_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 2 ns period.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
    endtask

    // Applies one request to the predicted heap and returns the result it causes.
    task automatic apply_heap_request(input t_kind kind, input logic [KEY_W-1:0] key,
                                      output t_rsp rsp);
        int               pos;
        int               up;
        int               best;
        int               lc;
        int               rc;
        bit               done;
        logic [KEY_W-1:0] tmp;
        t_status          st;
        st = ST_OK;
        if (kind == REQ_PUSH) begin
            if (heap_fill >= CAPACITY) begin
                st = ST_PUSH_FULL;
                n_push_full++;
            end else begin
                // Append and rise while strictly smaller than the parent.
                heap_keys[heap_fill] = key;
                pos = heap_fill;
                heap_fill++;
                done = 1'b0;
                while (pos > 0 && !done) begin
                    up = (pos - 1) / 2;
                    if (heap_keys[pos] < heap_keys[up]) begin
                        tmp             = heap_keys[pos];
                        heap_keys[pos]  = heap_keys[up];
                        heap_keys[up]   = tmp;
                        pos = up;
                    end else begin
                        done = 1'b1;
                    end
                end
                n_push_ok++;
            end
        end else begin
            if (heap_fill == 0) begin
                st = ST_POP_EMPTY;
                n_pop_empty++;
            end else begin
                // Move the last entry to the root and sink it; the left child wins a tie.
                heap_fill--;
                heap_keys[0] = heap_keys[heap_fill];
                pos = 0;
                done = 1'b0;
                while (pos < heap_fill && !done) begin
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    best = pos;
                    if (lc < heap_fill && heap_keys[lc] < heap_keys[best])
                        best = lc;
                    if (rc < heap_fill && heap_keys[rc] < heap_keys[best])
                        best = rc;
                    if (best == pos) begin
                        done = 1'b1;
                    end else begin
                        tmp              = heap_keys[pos];
                        heap_keys[pos]   = heap_keys[best];
                        heap_keys[best]  = tmp;
                        pos = best;
                    end
                end
                n_pop_ok++;
            end
        end
        rsp.min_key     = (heap_fill > 0) ? heap_keys[0] : '0;
        rsp.is_empty    = (heap_fill == 0);
        rsp.entry_count = CNT_W'(heap_fill);
        rsp.status      = st;
    endtask

    // Offers one request after a random gap and records its result once accepted.
    task automatic send_request(input t_kind kind, input logic [KEY_W-1:0] key,
                                input bit typed, input t_rsp typed_rsp);
        int   gap;
        t_rsp rsp;
        gap = tx_no_idle ? 0 : $urandom_range(GAP_MAX, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_heap_request(kind, key, rsp);
        pending_results.insert(pending_results.size(), typed ? typed_rsp : rsp);
        accepted_reqs++;
    endtask

    // Compares one result, field by field, with the oldest expectation.
    task automatic check_result(input logic [47:0] beat);
        t_rsp want;
        checked_rsps++;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending", beat[31:0], '0);
            return;
        end
        want = pending_results.pop_front();
        if (beat[31:0] !== want.min_key)
            report_mismatch("min_key", beat[31:0], want.min_key);
        if (beat[32] !== want.is_empty)
            report_mismatch("is_empty", 32'(beat[32]), 32'(want.is_empty));
        if (beat[39:33] !== want.entry_count)
            report_mismatch("entry_count", 32'(beat[39:33]), 32'(want.entry_count));
        if (beat[41:40] !== want.status)
            report_mismatch("status", 32'(beat[41:40]), 32'(want.status));
        if (beat[47:42] !== '0)
            report_mismatch("padding", 32'(beat[47:42]), '0);
    endtask

    function automatic void add_row(input t_kind kind, input logic [KEY_W-1:0] key,
                                    input bit typed, input logic [KEY_W-1:0] min_key,
                                    input logic empty, input int count, input t_status st);
        t_row row;
        row.kind                = kind;
        row.key                 = key;
        row.typed               = typed;
        row.rsp.min_key         = min_key;
        row.rsp.is_empty        = empty;
        row.rsp.entry_count     = CNT_W'(count);
        row.rsp.status          = st;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Request source: reset, the directed table, random phases, then the drain.
    initial begin : stimulus
        int               phase_num;
        int               phase_len;
        int               push_pct;
        int               rnd_sent;
        t_kind            kind;
        logic [KEY_W-1:0] key;
        t_rsp             none;
        none = '0;

        // Pop on empty, extreme keys, ties, draining to empty and past it.
        add_row(REQ_POP,  32'h1234_5678, 1, 32'h0,         1, 0, ST_POP_EMPTY);
        add_row(REQ_PUSH, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 1, ST_OK);
        add_row(REQ_PUSH, 32'h0000_0000, 1, 32'h0,         0, 2, ST_OK);
        add_row(REQ_PUSH, 32'h0000_0000, 1, 32'h0,         0, 3, ST_OK);
        add_row(REQ_PUSH, 32'h8000_0000, 0, '0, 0, 0, ST_OK);
        add_row(REQ_PUSH, 32'h0000_0007, 0, '0, 0, 0, ST_OK);
        add_row(REQ_PUSH, 32'h0000_0007, 0, '0, 0, 0, ST_OK);
        add_row(REQ_PUSH, 32'h0000_0001, 0, '0, 0, 0, ST_OK);
        repeat (6) add_row(REQ_POP, 32'hFFFF_FFFF, 0, '0, 0, 0, ST_OK);
        add_row(REQ_POP,  32'h0000_0000, 1, 32'h0,         1, 0, ST_OK);
        add_row(REQ_POP,  32'h0000_0000, 1, 32'h0,         1, 0, ST_POP_EMPTY);
        add_row(REQ_PUSH, 32'hAAAA_AAAA, 0, '0, 0, 0, ST_OK);
        add_row(REQ_PUSH, 32'h5555_5555, 0, '0, 0, 0, ST_OK);
        add_row(REQ_POP,  32'h0F0F_0F0F, 0, '0, 0, 0, ST_OK);
        add_row(REQ_POP,  32'hF0F0_F0F0, 1, 32'h0,         1, 0, ST_OK);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].key,
                         directed_rows[i].typed, directed_rows[i].rsp);

        // Random phases: first fill past full, then drain past empty, then a mix.
        rnd_sent  = 0;
        phase_num = 0;
        while (rnd_sent < RANDOM_ITEMS) begin
            if (phase_num == 0) begin
                phase_len = 72;
                push_pct  = 100;
            end else if (phase_num == 1) begin
                phase_len = 72;
                push_pct  = 0;
            end else begin
                phase_len = $urandom_range(120, 20);
                case ($urandom_range(2, 0))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            tx_no_idle = (phase_num > 1) && ($urandom_range(3, 0) == 0);
            for (int k = 0; k < phase_len; k++) begin
                kind = ($urandom_range(99, 0) < push_pct) ? REQ_PUSH : REQ_POP;
                // Small keys force ties; the rest spans the whole key range.
                case ($urandom_range(7, 0))
                    0:       key = 32'h0000_0000;
                    1:       key = 32'hFFFF_FFFF;
                    2, 3:    key = $urandom_range(15, 0);
                    4:       key = 32'hFFFF_FFF0 | $urandom_range(15, 0);
                    default: key = $urandom;
                endcase
                send_request(kind, key, 0, none);
                rnd_sent++;
            end
            phase_num++;
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every owed result, then a little longer for stray ones.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d stored pushes, %0d pushes dropped when full,",
                 n_push_ok, n_push_full);
        $display("%0d pops and %0d pops on empty; checked %0d results, one hold-off of %0d cycles.",
                 n_pop_ok, n_pop_empty, checked_rsps, HOLD_CYCLES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result receiver: random stalls, with stretches of none.
    initial begin : result_sink
        int stall;
        int streak;
        bit no_idle;
        streak  = 0;
        no_idle = 1'b0;
        wait (i_rst_n);
        forever begin
            if (streak == 0) begin
                streak  = $urandom_range(60, 10);
                no_idle = ($urandom_range(3, 0) == 0);
            end
            streak--;
            stall = no_idle ? 0 : $urandom_range(GAP_MAX, 0);
            if (stall > 0) begin
                rx_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rx_ready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            check_result(m_axis_tdata);
        end
    end

    // One long receiver hold-off so the block backs up and stalls its input.
    initial begin : sink_hold_off
        wait (accepted_reqs >= HOLD_AFTER);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog: ends the run when no request or result moves for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
